>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/wsd_pkg.sv
`default_nettype none
package wsd_pkg;

  localparam logic [7:0] CLOSE_BYTE = 8'h88;
  localparam logic [6:0] LEN_MASK   = 7'h7F;
  localparam logic [6:0] LEN_EXT16  = 7'd126;
  localparam logic [6:0] LEN_EXT64  = 7'd127;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    PH_FIRST = 5'b00001,
    PH_LEN   = 5'b00010,
    PH_EXT   = 5'b00100,
    PH_MASK  = 5'b01000,
    PH_DATA  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

>>> design/wsd_in_stage.sv
`default_nettype none
module wsd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_rx_byte,
  output logic            in_stall,
  input  wire logic       blocked,
  output logic            s1_valid,
  output logic [7:0]      s1_byte
);
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       accept;

  // the held item moves on whenever the result register can take it
  assign in_stall = s1_valid_r && blocked;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (!blocked) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;
endmodule
`default_nettype wire

>>> design/wsd_parser.sv
`default_nettype none
module wsd_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output wsd_pkg::res_t   res
);
  import wsd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        closed_r, closed_nxt;
  logic        ext64_r, ext64_nxt;
  logic [6:0]  len;
  logic [2:0]  ext_last_cnt;
  logic [63:0] rem_dec;
  logic [7:0]  key_byte;

  assign len          = rx_byte[6:0] & LEN_MASK;
  assign ext_last_cnt = ext64_r ? 3'd7 : 3'd1;
  assign rem_dec      = rem_r - 64'd1;
  // key bytes are stored first-received most significant
  assign key_byte     = key_r[{~idx_r, 3'b000} +: 8];

  always_comb begin
    phase_nxt  = phase_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    closed_nxt = closed_r;
    ext64_nxt  = ext64_r;
    res        = '{valid: 1'b0, kind: KIND_DATA, data: 8'd0, last: 1'b0};
    if (step && !closed_r) begin
      unique case (phase_r)
        PH_LEN: begin
          cnt_nxt = 3'd0;
          if (len == LEN_EXT16) begin
            rem_nxt   = 64'd0;
            ext64_nxt = 1'b0;
            phase_nxt = PH_EXT;
          end else if (len == LEN_EXT64) begin
            rem_nxt   = 64'd0;
            ext64_nxt = 1'b1;
            phase_nxt = PH_EXT;
          end else begin
            rem_nxt   = {57'd0, len};
            phase_nxt = PH_MASK;
          end
        end
        PH_EXT: begin
          rem_nxt = {rem_r[55:0], rx_byte};
          if (cnt_r >= ext_last_cnt) begin
            cnt_nxt   = 3'd0;
            phase_nxt = PH_MASK;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], rx_byte};
          if (cnt_r >= 3'd3) begin
            cnt_nxt = 3'd0;
            idx_nxt = 2'd0;
            if (rem_r == 64'd0) begin
              phase_nxt = PH_FIRST;
              res = '{valid: 1'b1, kind: KIND_EMPTY, data: 8'd0, last: 1'b1};
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_DATA: begin
          idx_nxt = idx_r + 2'd1;
          rem_nxt = rem_dec;
          if (rem_dec == 64'd0) begin
            phase_nxt = PH_FIRST;
          end
          res = '{valid: 1'b1, kind: KIND_DATA, data: rx_byte ^ key_byte,
                  last: (rem_dec == 64'd0)};
        end
        default: begin
          // first header byte, also taken for any code that cannot arise
          if (rx_byte == CLOSE_BYTE) begin
            closed_nxt = 1'b1;
            phase_nxt  = PH_FIRST;
            res = '{valid: 1'b1, kind: KIND_CLOSE, data: 8'd0, last: 1'b1};
          end else begin
            phase_nxt = PH_LEN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      rem_r    <= 64'd0;
      cnt_r    <= 3'd0;
      key_r    <= 32'd0;
      idx_r    <= 2'd0;
      closed_r <= 1'b0;
      ext64_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      rem_r    <= rem_nxt;
      cnt_r    <= cnt_nxt;
      key_r    <= key_nxt;
      idx_r    <= idx_nxt;
      closed_r <= closed_nxt;
      ext64_r  <= ext64_nxt;
    end
  end
endmodule
`default_nettype wire

>>> design/wsd_out_stage.sv
`default_nettype none
module wsd_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire wsd_pkg::res_t res,
  output logic               blocked,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_payload_byte,
  output logic               out_last
);
  import wsd_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  kind_t      kind_r;
  logic [7:0] data_r;
  logic       last_r;

  assign blocked = out_valid_r && out_stall;
  // when not blocked the register is either empty or being taken this edge
  assign out_valid_nxt = blocked ? 1'b1 : (step && res.valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!blocked && step && res.valid) begin
      kind_r <= res.kind;
      data_r <= res.data;
      last_r <= res.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_payload_byte = data_r;
  assign out_last         = last_r;
endmodule
`default_nettype wire

>>> design/websocket_frame_unmasking_deframer.sv
// websocket frame deframer with unmasking
// in channel: one raw received byte per item on in_rx_byte, in_valid/in_stall
// out channel: out_kind (0 payload byte, 1 empty message, 2 close seen),
//   out_payload_byte (unmasked byte, zero for events) and out_last,
//   out_valid/out_stall
// header bytes cause no item; each payload byte causes one item, a zero
//   length frame one empty item after its mask key, a 0x88 first byte a
//   close item, after which every byte is swallowed until reset
// throughput: one byte per cycle unless the receiver stalls, set by the
//   combinational parser step between the input and result registers
// an accepted byte is held in the input register; the parser result for it
//   is then registered in the result register, which drives out_valid
// reset (rst_n low, synchronous) empties both registers and returns the
//   parser to the first header byte with the close flag cleared
// a receiver stall on a held result freezes the parser; at most one more
//   byte is taken into the input register, then in_stall stays high until
//   the result is taken
`default_nettype none
module websocket_frame_unmasking_deframer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_payload_byte,
  output logic            out_last
);
  import wsd_pkg::*;

  logic       blocked;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       step;
  res_t       res;

  assign step = s1_valid && !blocked;

  wsd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .blocked    (blocked),
    .s1_valid   (s1_valid),
    .s1_byte    (s1_byte)
  );

  wsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (s1_byte),
    .res     (res)
  );

  wsd_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .res              (res),
    .blocked          (blocked),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last)
  );
endmodule
`default_nettype wire

>>> design/wsd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module wsd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_rx_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_payload_byte,
  input wire logic       out_last
);
  import wsd_pkg::*;

  logic [9:0] unused_in;
  assign unused_in = {in_valid, in_rx_byte, 1'b0};

  `ASSERT_RST(a_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_payload_byte) && $stable(out_last), "held result changed")
  `ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> out_valid && out_stall, "input stalled without a held result")
  `ASSERT_RST(a_event_shape, clk, rst_n, out_valid && out_kind != KIND_DATA |-> out_payload_byte == 8'd0 && out_last, "event item malformed")
  `ASSERT_RST(a_close_final, clk, rst_n, out_valid && !out_stall && out_kind == KIND_CLOSE |=> !out_valid, "item after close")
endmodule

bind websocket_frame_unmasking_deframer wsd_checker u_wsd_checker (.*);
`default_nettype wire

>>> tb/sv/websocket_frame_unmasking_deframer_test.sv
`timescale 1ns / 100ps
module websocket_frame_unmasking_deframer_test;
  import wsd_pkg::*;

  localparam int LONG_HOLD = 300;
  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 280;

  typedef enum {LS_SHORT, LS_EXT16, LS_EXT64} len_form_t;
  typedef logic [7:0] bytes_t[$];

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } deframed_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_payload_byte;
  logic       out_last;

  websocket_frame_unmasking_deframer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_payload_byte(out_payload_byte),
    .out_last(out_last)
  );

  always #10 clk = ~clk;

  // parser state as the block should hold it
  phase_t      parse_phase = PH_FIRST;
  logic [63:0] bytes_left = '0;
  logic [2:0]  section_count = '0;
  logic [3:0]  ext_len_bytes = '0;
  logic [31:0] mask_word = '0;
  logic [1:0]  mask_pos = '0;
  logic        close_seen = 1'b0;

  deframed_t expected_q[$];

  int mismatches = 0;
  int results_checked = 0;
  int bytes_in = 0;
  int frames_sent = 0;
  int empty_frames = 0;
  int ext16_frames = 0;
  int ext64_frames = 0;
  int stuck_cycles = 0;

  // sender shaping
  bit bursty = 1'b1;
  int burst_left = 0;

  // receiver shaping
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int pattern_left = 0;
  int stall_pct = 0;

  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] k;
    deframed_t r;
    if (close_seen) return;
    case (parse_phase)
      PH_LEN: begin
        section_count = '0;
        if (b[6:0] == LEN_EXT16) begin
          bytes_left = '0;
          ext_len_bytes = 4'd2;
          parse_phase = PH_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          bytes_left = '0;
          ext_len_bytes = 4'd8;
          parse_phase = PH_EXT;
        end else begin
          bytes_left = 64'(b[6:0]);
          parse_phase = PH_MASK;
        end
      end
      PH_EXT: begin
        bytes_left = {bytes_left[55:0], b};
        if (section_count + 4'd1 >= ext_len_bytes) begin
          section_count = '0;
          parse_phase = PH_MASK;
        end else begin
          section_count = section_count + 3'd1;
        end
      end
      PH_MASK: begin
        mask_word = {mask_word[23:0], b};
        if (section_count >= 3'd3) begin
          section_count = '0;
          mask_pos = '0;
          if (bytes_left == 0) begin
            parse_phase = PH_FIRST;
            r.kind = KIND_EMPTY;
            r.data = 8'h00;
            r.last = 1'b1;
            expected_q = {expected_q, r};
          end else begin
            parse_phase = PH_DATA;
          end
        end else begin
          section_count = section_count + 3'd1;
        end
      end
      PH_DATA: begin
        // first key byte received is the most significant one
        k = mask_word[31 - 8 * mask_pos -: 8];
        mask_pos = mask_pos + 2'd1;
        bytes_left = bytes_left - 64'd1;
        if (bytes_left == 0) parse_phase = PH_FIRST;
        r.kind = KIND_DATA;
        r.data = b ^ k;
        r.last = (bytes_left == 0);
        expected_q = {expected_q, r};
      end
      default: begin
        if (b == CLOSE_BYTE) begin
          close_seen = 1'b1;
          parse_phase = PH_FIRST;
          r.kind = KIND_CLOSE;
          r.data = 8'h00;
          r.last = 1'b1;
          expected_q = {expected_q, r};
        end else begin
          parse_phase = PH_LEN;
        end
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (bursty && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    bytes_in++;
    deframe_byte(b);
  endtask

  task automatic drive_frame(input logic [7:0] first, input len_form_t form,
                             input logic mask_bit, input logic [31:0] key,
                             input bytes_t body);
    logic [63:0] len;
    len = 64'(body.size());
    frames_sent++;
    if (body.size() == 0) empty_frames++;
    send_byte(first);
    case (form)
      LS_SHORT: send_byte({mask_bit, len[6:0]});
      LS_EXT16: begin
        ext16_frames++;
        send_byte({mask_bit, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        ext64_frames++;
        send_byte({mask_bit, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    foreach (body[i]) send_byte(body[i]);
  endtask

  function automatic bytes_t random_body(input int n);
    bytes_t body;
    for (int i = 0; i < n; i++) body = {body, 8'($urandom_range(0, 255))};
    return body;
  endfunction

  task automatic test_empty_frame();
    bytes_t none;
    drive_frame(8'h81, LS_SHORT, 1'b1, 32'h1234_5678, none);
  endtask

  task automatic test_extreme_bytes();
    bytes_t body;
    // mask bit clear, all-ones first byte, extremes in key and payload
    body = '{8'h00, 8'hFF, 8'h88, 8'h5A};
    drive_frame(8'hFF, LS_SHORT, 1'b0, 32'hFF00_A5C3, body);
  endtask

  task automatic test_ext16_length();
    bytes_t body;
    body = '{8'hFF, 8'h00, 8'h3C};
    drive_frame(8'h82, LS_EXT16, 1'b1, 32'hFFFF_FFFF, body);
  endtask

  task automatic test_ext64_length();
    bytes_t body;
    body = '{8'hC3, 8'h7E};
    drive_frame(8'h00, LS_EXT64, 1'b0, 32'h0000_0000, body);
  endtask

  task automatic test_close_byte_as_data();
    bytes_t body;
    // length byte comes out as 0x88 too: mask bit set, length 8
    body = '{8'h88, 8'h88, 8'h00, 8'hFF, 8'h88, 8'h01, 8'h80, 8'h88};
    drive_frame(8'h01, LS_SHORT, 1'b1, 32'h8800_88FF, body);
  endtask

  task automatic test_random_frames();
    bytes_t body;
    len_form_t form;
    logic [7:0] first;
    int pick;
    int n;
    int start_bytes;
    start_bytes = bytes_in;
    while (bytes_in - start_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) form = LS_SHORT;
      else if (pick < 85) form = LS_EXT16;
      else form = LS_EXT64;
      pick = $urandom_range(0, 99);
      if (pick < 12) n = 0;
      else if (pick < 96) n = $urandom_range(1, 12);
      else n = (form == LS_SHORT) ? $urandom_range(13, 125) : $urandom_range(13, 300);
      do first = 8'($urandom_range(0, 255)); while (first == CLOSE_BYTE);
      body = random_body(n);
      drive_frame(first, form, 1'($urandom_range(0, 1)), $urandom(), body);
    end
  endtask

  task automatic test_receiver_backpressure();
    hold_asked++;
    bursty = 1'b0;
    drive_frame(8'h82, LS_EXT16, 1'b1, $urandom(), random_body(40));
    bursty = 1'b1;
  endtask

  task automatic test_close_and_after();
    bytes_t tail;
    send_byte(CLOSE_BYTE);
    // everything after the close is swallowed, header-looking bytes included
    tail = '{CLOSE_BYTE, 8'h81, 8'h85, 8'h00, 8'hFF};
    foreach (tail[i]) send_byte(tail[i]);
    repeat (6) send_byte(8'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served++;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      pattern_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    deframed_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      results_checked++;
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item %0d: kind %0d byte %02h last %0b",
                   results_checked, out_kind, out_payload_byte, out_last);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_kind !== want.kind || out_payload_byte !== want.data ||
            out_last !== want.last) begin
          if (mismatches < 10)
            $display("item %0d: expected kind %0d byte %02h last %0b, %s %0d %s %02h %s %0b",
                     results_checked, want.kind, want.data, want.last,
                     "got kind", out_kind, "byte", out_payload_byte,
                     "last", out_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall == 1'b0))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("no progress for %0d cycles, %0d items still expected",
               stuck_cycles, expected_q.size());
      $display("websocket_frame_unmasking_deframer regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_frame();
    test_extreme_bytes();
    test_ext16_length();
    test_ext64_length();
    test_close_byte_as_data();
    test_random_frames();
    test_receiver_backpressure();
    test_close_and_after();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bytes in %0d frames: %0d empty, %0d with 16-bit, %0d with 64-bit length",
             bytes_in, frames_sent, empty_frames, ext16_frames, ext64_frames);
    $display("checked %0d items incl. a long receiver hold and bytes after close, %0d mismatches",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("websocket_frame_unmasking_deframer regression: pass");
    end else begin
      $display("websocket_frame_unmasking_deframer regression: fail");
    end
    $finish;
  end

endmodule
